>>> design/qped_pkg.sv
// shared types, character codes and helper functions for the query parameter decoder
package qped_pkg;

  localparam int KEY_W = 64;
  localparam int KLEN_W = 4;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = 2;
  localparam int OQ_CW = 3;

  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [4:0] HEX_BAD = 5'd20;

  localparam logic CFG_KEY_CHARS = 1'b0;
  localparam logic CFG_KEY_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_EMIT = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       key_found;
    logic       value_last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_set_t;

  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end else begin
      v = HEX_BAD;
    end
    return v;
  endfunction

  function automatic logic [7:0] plus_map(logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  function automatic res_t val_res(logic [7:0] b, logic last);
    res_t r;
    r.out_byte = b;
    r.byte_valid = 1'b1;
    r.key_found = 1'b1;
    r.value_last = last;
    return r;
  endfunction

  function automatic res_set_t put_res(res_set_t s, res_t r);
    res_set_t o;
    o = s;
    if (s.cnt == 2'd0) begin
      o.r0 = r;
      o.cnt = 2'd1;
    end else if (s.cnt == 2'd1) begin
      o.r1 = r;
      o.cnt = 2'd2;
    end
    return o;
  endfunction

  // close the value: flush held escape bytes, mark the last result, or push an empty last result
  function automatic res_set_t term_res(res_set_t s, logic [1:0] pc, logic [7:0] pd);
    res_set_t o;
    res_t e;
    o = s;
    e = '0;
    if (pc == 2'd1) begin
      o = put_res(o, val_res(CH_PCT, 1'b1));
    end else if (pc == 2'd2) begin
      o = put_res(o, val_res(CH_PCT, 1'b0));
      o = put_res(o, val_res(plus_map(pd), 1'b1));
    end else if (s.cnt == 2'd1) begin
      o.r0.value_last = 1'b1;
    end else if (s.cnt == 2'd2) begin
      o.r1.value_last = 1'b1;
    end else begin
      e.key_found = 1'b1;
      e.value_last = 1'b1;
      o = put_res(o, e);
    end
    return o;
  endfunction

endpackage

>>> design/query_param_extract_decode_core.sv
// top level of the query parameter extractor with url percent decoding
// Takes one query string byte per cycle: the key window compare and the escape
// decode finish in the cycle the byte is taken, and results enter a four-entry
// queue in front of the output. The input is ready whenever that queue has room
// for two results, so a byte a cycle is sustained while the output drains; a
// byte that yields two results (a bad escape or a value closed with a held
// escape) pushes both into the queue at once. Write configuration only while idle.
module query_param_extract_decode_core #(
  parameter int MAX_KEY = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // in_char
  input  logic                       s_axis_tuser,   // char_present
  input  logic                       s_axis_tlast,   // string_end
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // out_byte
  output logic [1:0]                 m_axis_tuser,   // byte_valid, key_found
  output logic                       m_axis_tlast,   // value_last
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [qped_pkg::KEY_W-1:0] cfg_data
);

  localparam int LW = $clog2(MAX_KEY + 1);

  logic [qped_pkg::KEY_W-1:0]  key_chars;
  logic [qped_pkg::KLEN_W-1:0] key_length;
  logic [LW-1:0]               len;
  logic                        accept;
  logic                        shift;
  logic                        hit;
  logic                        room;
  qped_pkg::res_set_t          res;
  qped_pkg::res_t              head;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars <= '0;
      key_length <= qped_pkg::KLEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        qped_pkg::CFG_KEY_CHARS: key_chars <= cfg_data;
        qped_pkg::CFG_KEY_LENGTH: key_length <= cfg_data[qped_pkg::KLEN_W-1:0];
        default: key_chars <= key_chars;
      endcase
    end
  end

  assign len = (key_length > qped_pkg::KLEN_W'(MAX_KEY)) ? LW'(MAX_KEY) : LW'(key_length);
  assign s_axis_tready = room;
  assign accept = s_axis_tvalid && s_axis_tready;

  qped_window #(
    .MAX_KEY(MAX_KEY),
    .LW(LW)
  ) u_window (
    .clk(clk),
    .rst(rst),
    .shift(shift),
    .clear(accept && s_axis_tlast),
    .in_char(s_axis_tdata),
    .key_chars(key_chars),
    .len(len),
    .hit(hit)
  );

  qped_decode u_decode (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .in_char(s_axis_tdata),
    .char_present(s_axis_tuser),
    .string_end(s_axis_tlast),
    .len_zero(key_length == '0),
    .hit(hit),
    .shift(shift),
    .res(res)
  );

  qped_outq u_outq (
    .clk(clk),
    .rst(rst),
    .push(res),
    .pop(m_axis_tvalid && m_axis_tready),
    .head(head),
    .head_valid(m_axis_tvalid),
    .room(room)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {head.key_found, head.byte_valid};
  assign m_axis_tlast = head.value_last;

endmodule

>>> design/qped_window.sv
// sliding byte window and key compare for the search phase
module qped_window #(
  parameter int MAX_KEY = 8,
  parameter int LW = $clog2(MAX_KEY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     shift,
  input  logic                     clear,
  input  logic [7:0]               in_char,
  input  logic [qped_pkg::KEY_W-1:0] key_chars,
  input  logic [LW-1:0]            len,
  output logic                     hit
);

  logic [7:0]    win [MAX_KEY];
  logic [7:0]    win_next [MAX_KEY];
  logic [LW-1:0] fill;
  logic [LW-1:0] fill_next;
  logic [2:0]    kidx;

  always_comb begin
    win_next[0] = in_char;
    for (int i = 1; i < MAX_KEY; i++) begin
      win_next[i] = win[i-1];
    end
    fill_next = (fill == LW'(MAX_KEY)) ? fill : fill + LW'(1);
    hit = (fill_next >= len);
    kidx = '0;
    // newest byte pairs with the last key byte in use
    for (int j = 0; j < MAX_KEY; j++) begin
      if (LW'(j) < len) begin
        kidx = 3'(int'(len) - 1 - j);
        if (win_next[j] != key_chars[8*kidx +: 8]) begin
          hit = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
      for (int i = 0; i < MAX_KEY; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      fill <= fill_next;
      for (int i = 0; i < MAX_KEY; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule

>>> design/qped_decode.sv
// phase tracking and percent/plus decoding of the value bytes
module qped_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_char,
  input  logic                char_present,
  input  logic                string_end,
  input  logic                len_zero,
  input  logic                hit,
  output logic                shift,
  output qped_pkg::res_set_t  res
);

  qped_pkg::phase_t   phase, phase_next;
  logic [1:0]         pc, pc_next;
  logic [7:0]         pd, pd_next;
  qped_pkg::res_set_t s;
  logic [4:0]         ha, hb;
  logic [7:0]         d;

  always_comb begin
    phase_next = phase;
    pc_next = pc;
    pd_next = pd;
    s = '0;
    shift = 1'b0;
    ha = qped_pkg::hex_val(pd);
    hb = qped_pkg::hex_val(in_char);
    d = pd;
    if (accept && (char_present || string_end)) begin
      if (phase_next == qped_pkg::PH_SEARCH && len_zero) begin
        phase_next = qped_pkg::PH_EMIT;
      end
      if (char_present) begin
        if (phase_next == qped_pkg::PH_SEARCH) begin
          shift = 1'b1;
          if (hit) begin
            phase_next = qped_pkg::PH_EMIT;
          end
        end else if (phase_next == qped_pkg::PH_EMIT) begin
          if (in_char == qped_pkg::CH_AMP) begin
            s = qped_pkg::term_res(s, pc_next, pd_next);
            pc_next = 2'd0;
            pd_next = '0;
            phase_next = qped_pkg::PH_DONE;
          end else begin
            if (pc_next == 2'd2) begin
              pc_next = 2'd0;
              pd_next = '0;
              if (ha != qped_pkg::HEX_BAD && hb != qped_pkg::HEX_BAD) begin
                s = qped_pkg::put_res(s, qped_pkg::val_res({ha[3:0], hb[3:0]}, 1'b0));
              end else if (d == qped_pkg::CH_PCT) begin
                // bad escape: rescan the held byte, which opens a new escape
                pc_next = 2'd1;
              end else begin
                s = qped_pkg::put_res(s, qped_pkg::val_res(qped_pkg::plus_map(d), 1'b0));
              end
            end
            if (pc_next == 2'd0 && !(s.cnt == 2'd1 && ha != qped_pkg::HEX_BAD &&
                hb != qped_pkg::HEX_BAD && pc == 2'd2)) begin
              if (in_char == qped_pkg::CH_PCT) begin
                pc_next = 2'd1;
              end else begin
                s = qped_pkg::put_res(s,
                  qped_pkg::val_res(qped_pkg::plus_map(in_char), 1'b0));
              end
            end else if (pc_next == 2'd1) begin
              pc_next = 2'd2;
              pd_next = in_char;
            end
          end
        end
      end
      if (string_end) begin
        if (phase_next == qped_pkg::PH_SEARCH) begin
          s.cnt = 2'd1;
          s.r0 = '0;
          s.r0.value_last = 1'b1;
        end else if (phase_next == qped_pkg::PH_EMIT) begin
          s = qped_pkg::term_res(s, pc_next, pd_next);
        end
        phase_next = qped_pkg::PH_SEARCH;
        pc_next = 2'd0;
        pd_next = '0;
      end
    end
    res = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= qped_pkg::PH_SEARCH;
      pc <= 2'd0;
      pd <= '0;
    end else begin
      phase <= phase_next;
      pc <= pc_next;
      pd <= pd_next;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc != 2'd3)
    else $error("escape hold count out of range");

  a_pc_emit_only: assert property (@(posedge clk) disable iff (rst)
    pc != 2'd0 |-> phase == qped_pkg::PH_EMIT)
    else $error("escape bytes held outside the value");

  a_pair_bytes: assert property (@(posedge clk) disable iff (rst)
    res.cnt == 2'd2 |-> res.r0.byte_valid && res.r1.byte_valid && !res.r0.value_last)
    else $error("bad result pair");

endmodule

>>> design/qped_outq.sv
// four-entry result queue taking up to two results per cycle
module qped_outq (
  input  logic               clk,
  input  logic               rst,
  input  qped_pkg::res_set_t push,
  input  logic               pop,
  output qped_pkg::res_t     head,
  output logic               head_valid,
  output logic               room
);

  qped_pkg::res_t               mem [qped_pkg::OQ_DEPTH];
  logic [qped_pkg::OQ_AW-1:0]   wp, rp;
  logic [qped_pkg::OQ_CW-1:0]   count;

  assign head = mem[rp];
  assign head_valid = (count != '0);
  assign room = (count <= qped_pkg::OQ_CW'(qped_pkg::OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp + qped_pkg::OQ_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + qped_pkg::OQ_AW'(push.cnt);
      rp <= rp + qped_pkg::OQ_AW'(pop);
      count <= count + qped_pkg::OQ_CW'(push.cnt) - qped_pkg::OQ_CW'(pop);
    end
  end

endmodule

>>> test/query_param_extract_decode_checker.sv
// checker that predicts decoder results from input transfers and compares the output stream
module query_param_extract_decode_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // in_char
  input  logic                       s_axis_tuser,   // char_present
  input  logic                       s_axis_tlast,   // string_end
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [7:0]                 m_axis_tdata,   // out_byte
  input  logic [1:0]                 m_axis_tuser,   // byte_valid, key_found
  input  logic                       m_axis_tlast,   // value_last
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [qped_pkg::KEY_W-1:0] cfg_data,
  output int                         errors,
  output int                         results_due
);

  localparam int WIN = 8;

  logic [qped_pkg::KEY_W-1:0] key_bytes;
  logic [3:0]                 key_len;

  logic [7:0]        window [WIN];
  int                fill;
  qped_pkg::phase_t  phase;
  logic [1:0]        held_cnt;
  logic [7:0]        held_byte;

  qped_pkg::res_t    step_res [2];
  int                step_n;
  qped_pkg::res_t    decoded_q [$];

  function automatic int eff_len();
    return (key_len > WIN) ? WIN : int'(key_len);
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (lc >= 8'h61 && lc <= 8'h66) return {1'b0, 4'(c[3:0] + 4'd9)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] unplus(input logic [7:0] c);
    return (c == qped_pkg::CH_PLUS) ? qped_pkg::CH_SPACE : c;
  endfunction

  task automatic emit(input logic [7:0] b, input logic v, input logic f, input logic l);
    if (step_n < 2) begin
      step_res[step_n] = {b, v, f, l};
      step_n++;
    end
  endtask

  task automatic clear_string();
    for (int i = 0; i < WIN; i++) window[i] = 8'h00;
    fill = 0;
    phase = qped_pkg::PH_SEARCH;
    held_cnt = 2'd0;
    held_byte = 8'h00;
  endtask

  // byte that is not a terminator, with at most a '%' held
  task automatic take_plain(input logic [7:0] c);
    if (held_cnt == 2'd0) begin
      if (c == qped_pkg::CH_PCT) held_cnt = 2'd1;
      else emit(unplus(c), 1'b1, 1'b1, 1'b0);
    end else begin
      held_cnt = 2'd2;
      held_byte = c;
    end
  endtask

  task automatic take_value(input logic [7:0] c);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] first;
    if (held_cnt == 2'd2) begin
      first = held_byte;
      hi = hex_digit(first);
      lo = hex_digit(c);
      held_cnt = 2'd0;
      held_byte = 8'h00;
      if (!hi[4] && !lo[4]) begin
        emit({hi[3:0], lo[3:0]}, 1'b1, 1'b1, 1'b0);
      end else begin
        // bad escape: drop the '%' and rescan both bytes
        take_plain(first);
        take_plain(c);
      end
    end else begin
      take_plain(c);
    end
  endtask

  task automatic close_value();
    if (held_cnt == 2'd1) begin
      emit(qped_pkg::CH_PCT, 1'b1, 1'b1, 1'b1);
    end else if (held_cnt == 2'd2) begin
      emit(qped_pkg::CH_PCT, 1'b1, 1'b1, 1'b0);
      emit(unplus(held_byte), 1'b1, 1'b1, 1'b1);
    end else if (step_n > 0) begin
      step_res[step_n-1].value_last = 1'b1;
    end else begin
      emit(8'h00, 1'b0, 1'b1, 1'b1);
    end
    held_cnt = 2'd0;
    held_byte = 8'h00;
    phase = qped_pkg::PH_DONE;
  endtask

  task automatic scan_byte(input logic [7:0] c);
    int n;
    bit hit;
    n = eff_len();
    for (int i = WIN - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = c;
    if (fill < WIN) fill++;
    if (fill >= n) begin
      hit = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (window[n-1-i] != key_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) phase = qped_pkg::PH_EMIT;
    end
  endtask

  task automatic decode_step(input logic [7:0] c, input logic present, input logic fin);
    step_n = 0;
    if (present || fin) begin
      if (phase == qped_pkg::PH_SEARCH && eff_len() == 0) phase = qped_pkg::PH_EMIT;
      if (present) begin
        if (phase == qped_pkg::PH_SEARCH) begin
          scan_byte(c);
        end else if (phase == qped_pkg::PH_EMIT) begin
          if (c == qped_pkg::CH_AMP) close_value();
          else take_value(c);
        end
      end
      if (fin) begin
        if (phase == qped_pkg::PH_SEARCH) emit(8'h00, 1'b0, 1'b0, 1'b1);
        else if (phase == qped_pkg::PH_EMIT) close_value();
        clear_string();
      end
    end
    for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
  endtask

  task automatic report(input string what, input logic [11:0] want, input logic [11:0] got);
    $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    errors++;
  endtask

  task automatic check_result();
    qped_pkg::res_t want;
    if (decoded_q.size() == 0) begin
      report("unexpected result", 12'h0, {1'b0, m_axis_tdata, m_axis_tuser, m_axis_tlast});
      return;
    end
    want = decoded_q.pop_front();
    if (m_axis_tdata !== want.out_byte) report("out_byte", want.out_byte, m_axis_tdata);
    if (m_axis_tuser[0] !== want.byte_valid) report("byte_valid", want.byte_valid,
                                                    m_axis_tuser[0]);
    if (m_axis_tuser[1] !== want.key_found) report("key_found", want.key_found,
                                                   m_axis_tuser[1]);
    if (m_axis_tlast !== want.value_last) report("value_last", want.value_last, m_axis_tlast);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_bytes = '0;
      key_len = 4'd1;
      clear_string();
      decoded_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == qped_pkg::CFG_KEY_CHARS) key_bytes = cfg_data;
        else key_len = cfg_data[3:0];
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) decode_step(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
    results_due = decoded_q.size();
  end

endmodule

>>> test/query_param_extract_decode_core_tb.sv
// testbench top: drives query strings and key settings into the decoder and reports the verdict
module query_param_extract_decode_core_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 70;
  localparam logic [7:0] CH_EQ = 8'h3D;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata = 8'h00;   // in_char
  logic                       s_axis_tuser = 1'b0;    // char_present
  logic                       s_axis_tlast = 1'b0;    // string_end
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [7:0]                 m_axis_tdata;           // out_byte
  logic [1:0]                 m_axis_tuser;           // byte_valid, key_found
  logic                       m_axis_tlast;           // value_last
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [qped_pkg::KEY_W-1:0] cfg_data = '0;

  int          fail_count;
  int          results_due;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          rx_hold = 1'b0;
  logic [63:0] key_word = 64'h0;
  logic [3:0]  key_len = 4'd1;
  int          items_sent = 0;
  logic [7:0]  text [$];

  query_param_extract_decode_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  query_param_extract_decode_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (fail_count),
    .results_due   (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off when armed
  initial begin : rx_side
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (rx_hold && held < HOLD_CYCLES) begin
        m_axis_tready <= 1'b0;
        held++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[query_param_extract_decode_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] c, input logic present, input logic fin);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= present;
    s_axis_tlast <= fin;
    do @(posedge clk); while (!s_axis_tready);
    if (present || fin) items_sent++;
  endtask

  task automatic send_text(input bit bare_end);
    int last;
    last = text.size() - 1;
    foreach (text[i]) begin
      // occasional transfer with neither a byte nor an end
      if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(text[i], 1'b1, !bare_end && i == last);
    end
    if (bare_end || text.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_literal(input string s, input bit bare_end);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(bare_end);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] w, input logic [3:0] len);
    key_word = w;
    key_len = len;
    write_reg(qped_pkg::CFG_KEY_CHARS, w);
    write_reg(qped_pkg::CFG_KEY_LENGTH, {60'h0, len});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random key, usually ending in '='
  task automatic random_key(input logic [3:0] len);
    logic [63:0] w;
    int eff;
    eff = (len > 8) ? 8 : len;
    for (int i = 0; i < 8; i++)
      w[8*i +: 8] = ($urandom_range(99) < 20) ? 8'($urandom_range(255))
                                              : 8'h61 + 8'($urandom_range(25));
    if (eff > 0 && $urandom_range(3) != 0) w[8*(eff-1) +: 8] = CH_EQ;
    set_key(w, len);
  endtask

  // wait until every predicted result has come out, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  function automatic logic [7:0] value_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return hex_char();
    if (pick < 42) return qped_pkg::CH_PCT;
    if (pick < 54) return qped_pkg::CH_PLUS;
    if (pick < 60) return qped_pkg::CH_AMP;
    if (pick < 70) return 8'($urandom_range(255));
    return 8'h67 + 8'($urandom_range(19));
  endfunction

  task automatic build_query();
    int shape;
    int eff;
    text.delete();
    shape = $urandom_range(99);
    eff = (key_len > 8) ? 8 : key_len;
    repeat ($urandom_range(2)) begin
      repeat ($urandom_range(1, 3)) text.push_back(8'h61 + 8'($urandom_range(25)));
      text.push_back(CH_EQ);
      repeat ($urandom_range(3)) text.push_back(value_char());
      text.push_back(qped_pkg::CH_AMP);
    end
    if (shape < 80) begin
      for (int i = 0; i < eff; i++) text.push_back(key_word[8*i +: 8]);
      repeat ($urandom_range(8)) begin
        if ($urandom_range(3) == 0) begin
          text.push_back(qped_pkg::CH_PCT);
          text.push_back(($urandom_range(4) == 0) ? value_char() : hex_char());
          text.push_back(($urandom_range(4) == 0) ? value_char() : hex_char());
        end else begin
          text.push_back(value_char());
        end
      end
      if ($urandom_range(1)) begin
        text.push_back(qped_pkg::CH_AMP);
        repeat ($urandom_range(4)) text.push_back(value_char());
      end
    end else begin
      repeat ($urandom_range(12)) text.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    int start;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      build_query();
      send_text($urandom_range(2) == 0);
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    settle();

    // directed: key "q=" with decoded, bad and short escapes, not found, byte extremes
    set_key(64'h3D71, 4'd2);
    send_literal("q=%aF+", 1'b1);
    send_literal("q=%zz&x", 1'b0);
    send_literal("xq=%4", 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_literal("q=%", 1'b1);
    settle();

    run_phase(0, 0);
    set_key('1, 4'd8);
    run_phase(55, 0);
    // key holding '&'
    set_key(64'h3D622661, 4'd4);
    run_phase(0, 55);
    random_key(4'd1);
    run_phase(37, 37);
    // empty key, with the long receiver hold-off
    random_key(4'd0);
    rx_hold = 1'b1;
    run_phase(0, 0);
    random_key(4'd12);
    run_phase(37, 37);
    set_key(64'h0, 4'd3);
    run_phase(55, 0);
    random_key(4'd8);
    run_phase(0, 55);

    if (fail_count == 0 && results_due == 0) begin
      $display("[query_param_extract_decode_core] OK");
    end else begin
      $display("[query_param_extract_decode_core] ERROR");
    end
    $finish;
  end

endmodule
